// File: hw/rtl/ema_and_momentum_price_signal_top_macros.svh
// ----------------------------------------------------------------------------
// EMA and momentum signal assertion macros
// Shorthand for clocked assertions used by the block's checker.
// ----------------------------------------------------------------------------
`ifndef EMA_AND_MOMENTUM_PRICE_SIGNAL_TOP_MACROS_SVH
`define EMA_AND_MOMENTUM_PRICE_SIGNAL_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising edge of clock.
`define EMA_MOM_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising edge of clock.
`define EMA_MOM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/ema_mom_pkg.sv
// ----------------------------------------------------------------------------
// EMA and momentum signal package
// Widths, constants, shared types and the saturating earnings adder.
// ----------------------------------------------------------------------------
package ema_mom_pkg;

   localparam int PRICE_W       = 32;
   localparam int WINDOW        = 100;
   localparam int HISTORY_DEPTH = 128;
   localparam int EMA_FRAC_BITS = 16;

   localparam int EMA_W       = PRICE_W + EMA_FRAC_BITS;
   localparam int EMA_LEVEL_W = 48;
   localparam int EARN_W      = 48;
   localparam int SUM_W       = EARN_W + 1;
   localparam int THR_W       = 11;
   localparam int ACTION_W    = 2;

   localparam int TOTAL_W = PRICE_W + $clog2(WINDOW + 1);
   localparam int SLOT_W  = $clog2(HISTORY_DEPTH);
   localparam int CNT_W   = $clog2(WINDOW + 2);

   localparam int DVS_W     = $clog2(WINDOW + 2);
   localparam int DIV_BITS  = 8;
   localparam int DIV_ITERS = (TOTAL_W + EMA_FRAC_BITS + 1 + DIV_BITS - 1) / DIV_BITS;
   localparam int NUM_W     = DIV_ITERS * DIV_BITS;
   localparam int ITER_W    = $clog2(DIV_ITERS);
   localparam int SEED_HALF = WINDOW / 2;
   localparam int UPD_HALF  = (WINDOW + 1) / 2;

   localparam int MOM_W = PRICE_W + THR_W + 2;
   localparam logic signed [7:0] PCT_SCALE = 8'sd100;

   localparam logic signed [EARN_W-1:0] EARN_MAX = {1'b0, {(EARN_W-1){1'b1}}};
   localparam logic signed [EARN_W-1:0] EARN_MIN = {1'b1, {(EARN_W-1){1'b0}}};

   typedef enum logic [ACTION_W-1:0] {
      ACT_NONE = 2'd0,
      ACT_BUY  = 2'd1,
      ACT_SELL = 2'd2
   } action_type;

   typedef struct packed {
      logic [PRICE_W-1:0] price;
      logic [TOTAL_W-1:0] total;
      logic [PRICE_W-1:0] then_val;
      logic [PRICE_W:0]   mom_diff;
   } job_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DVS_W-1:0] dvs;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quotient;
   } div_rsp_type;

   function automatic logic signed [EARN_W-1:0] sat_add(
      input logic signed [EARN_W-1:0] a,
      input logic signed [PRICE_W:0]  d
   );
      logic signed [SUM_W-1:0]  s;
      logic signed [EARN_W-1:0] r;
      s = SUM_W'(a) + SUM_W'(d);
      if (s[SUM_W-1] != s[SUM_W-2]) begin
         r = s[SUM_W-1] ? EARN_MIN : EARN_MAX;
      end else begin
         r = s[EARN_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/ema_mom_ring.sv
// ----------------------------------------------------------------------------
// EMA and momentum price ring
// Stores prices in a ring memory, keeps the window sum and hands each
// evaluated beat to the signal core with its snapshot of the history.
// ----------------------------------------------------------------------------
module ema_mom_ring
   import ema_mom_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [PRICE_W-1:0] req_trade_price,
   input  logic               job_take,
   output logic               job_valid,
   output job_type            job
);

   logic [PRICE_W-1:0] ring_mem [HISTORY_DEPTH];
   logic [PRICE_W-1:0] rd_data_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic [SLOT_W-1:0]  rd_addr;
   logic [CNT_W-1:0]   cnt_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic [TOTAL_W-1:0] total_in;
   logic               a_valid_ff;
   logic               a_emit_ff;
   logic               a_sub_ff;
   logic [PRICE_W-1:0] a_price_ff;
   logic [PRICE_W-1:0] a_now_ff;
   logic [PRICE_W-1:0] last_ff;
   logic [PRICE_W-1:0] then_ff;
   logic               job_valid_ff;
   logic               job_valid_in;
   job_type            job_ff;
   logic               acc;

   assign req_ready = !a_valid_ff && !job_valid_ff;
   assign acc       = req_valid && req_ready;
   assign rd_addr   = slot_ff - SLOT_W'(WINDOW);
   assign job_valid = job_valid_ff;
   assign job       = job_ff;

   always_ff @(posedge clock) begin
      if (acc) begin
         ring_mem[slot_ff] <= req_trade_price;
         rd_data_ff        <= ring_mem[rd_addr];
      end
   end

   always_comb begin
      total_in = total_ff - (a_sub_ff ? TOTAL_W'(rd_data_ff) : '0) + TOTAL_W'(a_price_ff);
   end

   always_comb begin
      priority if (a_valid_ff && a_emit_ff) begin
         job_valid_in = 1'b1;
      end else if (job_take) begin
         job_valid_in = 1'b0;
      end else begin
         job_valid_in = job_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         cnt_ff       <= '0;
         total_ff     <= '0;
         a_valid_ff   <= 1'b0;
         job_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= acc;
         job_valid_ff <= job_valid_in;
         if (acc) begin
            slot_ff <= slot_ff + 1'b1;
            if (cnt_ff <= CNT_W'(WINDOW)) begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
         if (a_valid_ff) begin
            total_ff <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         a_price_ff <= req_trade_price;
         a_now_ff   <= last_ff;
         last_ff    <= req_trade_price;
         a_emit_ff  <= cnt_ff > CNT_W'(WINDOW);
         a_sub_ff   <= cnt_ff >= CNT_W'(WINDOW);
      end
      if (a_valid_ff) begin
         then_ff         <= rd_data_ff;
         job_ff.price    <= a_price_ff;
         job_ff.total    <= total_ff;
         job_ff.then_val <= then_ff;
         job_ff.mom_diff <= {1'b0, a_now_ff} - {1'b0, then_ff};
      end
   end

endmodule

// File: hw/rtl/ema_mom_div.sv
// ----------------------------------------------------------------------------
// EMA and momentum constant divider
// Restoring division by a small divisor, eight quotient bits per cycle.
// ----------------------------------------------------------------------------
module ema_mom_div
   import ema_mom_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [NUM_W-1:0]  work_ff;
   logic [NUM_W-1:0]  work_in;
   logic [DVS_W-1:0]  rem_ff;
   logic [DVS_W-1:0]  rem_in;
   logic [DVS_W-1:0]  dvs_ff;
   logic [ITER_W-1:0] iter_ff;
   logic              busy_ff;
   logic              done_ff;

   always_comb begin
      logic [DVS_W:0] trial;
      rem_in  = rem_ff;
      work_in = work_ff;
      for (int i = 0; i < DIV_BITS; i++) begin
         trial   = {rem_in, work_in[NUM_W-1]};
         work_in = {work_in[NUM_W-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in     = DVS_W'(trial - {1'b0, dvs_ff});
            work_in[0] = 1'b1;
         end else begin
            rem_in = trial[DVS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            iter_ff <= '0;
         end else if (busy_ff) begin
            iter_ff <= iter_ff + 1'b1;
            if (iter_ff == ITER_W'(DIV_ITERS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         work_ff <= div_req.num;
         rem_ff  <= '0;
         dvs_ff  <= div_req.dvs;
      end else if (busy_ff) begin
         work_ff <= work_in;
         rem_ff  <= rem_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = work_ff;

endmodule

// File: hw/rtl/ema_mom_core.sv
// ----------------------------------------------------------------------------
// EMA and momentum signal core
// Seeds and updates the moving average, evaluates both strategies, keeps
// their positions and earnings and holds the result beat for the output.
// ----------------------------------------------------------------------------
module ema_mom_core
   import ema_mom_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic signed [THR_W-1:0]  csr_momentum_threshold_pct,
   input  logic                     job_valid,
   input  job_type                  job,
   output logic                     job_take,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [EMA_LEVEL_W-1:0]   rsp_ema_level,
   output logic [ACTION_W-1:0]      rsp_ema_action,
   output logic                     rsp_ema_in_position,
   output logic signed [EARN_W-1:0] rsp_ema_profit,
   output logic [ACTION_W-1:0]      rsp_momentum_action,
   output logic                     rsp_momentum_in_position,
   output logic signed [EARN_W-1:0] rsp_momentum_profit
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_PREP   = 4'b0010,
      ST_DIV    = 4'b0100,
      ST_SIGNAL = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   logic signed [THR_W-1:0]  thr_ff;
   logic [EMA_W-1:0]         ema_ff;
   logic [EMA_W-1:0]         ema_in;
   logic                     started_ff;
   logic                     ema_hold_ff;
   logic signed [EARN_W-1:0] ema_earn_ff;
   logic                     mom_hold_ff;
   logic signed [EARN_W-1:0] mom_earn_ff;

   logic [PRICE_W-1:0]       w_price_ff;
   logic [TOTAL_W-1:0]       w_total_ff;
   logic                     w_then_zero_ff;
   logic                     w_ge_ff;
   logic [EMA_W-1:0]         w_mag_ff;
   logic signed [MOM_W-1:0]  lhs_ff;
   logic signed [MOM_W-1:0]  rhs_ff;
   logic signed [EARN_W-1:0] ema_buy_earn_ff;
   logic signed [EARN_W-1:0] ema_sell_earn_ff;
   logic signed [EARN_W-1:0] mom_buy_earn_ff;
   logic signed [EARN_W-1:0] mom_sell_earn_ff;

   logic [EMA_W-1:0]         job_pfx;
   logic [EMA_W-1:0]         w_pfx;
   logic signed [PRICE_W:0]  price_s;
   logic                     out_free;
   logic                     sig_fire;
   logic                     ema_buy;
   logic                     ema_sell;
   logic                     mom_buy;
   logic                     mom_sell;
   logic                     ema_hold_in;
   logic                     mom_hold_in;
   logic signed [EARN_W-1:0] ema_earn_in;
   logic signed [EARN_W-1:0] mom_earn_in;
   action_type               ema_act_in;
   action_type               mom_act_in;

   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [EMA_LEVEL_W-1:0]   rsp_level_ff;
   action_type               rsp_ema_act_ff;
   logic                     rsp_ema_pos_ff;
   logic signed [EARN_W-1:0] rsp_ema_profit_ff;
   action_type               rsp_mom_act_ff;
   logic                     rsp_mom_pos_ff;
   logic signed [EARN_W-1:0] rsp_mom_profit_ff;

   div_req_type div_req;
   div_rsp_type div_rsp;

   ema_mom_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign sig_fire = (state_ff == ST_SIGNAL) && out_free;
   assign job_take = job_valid && ((state_ff == ST_IDLE) || sig_fire);
   assign job_pfx  = {job.price, {EMA_FRAC_BITS{1'b0}}};
   assign w_pfx    = {w_price_ff, {EMA_FRAC_BITS{1'b0}}};
   assign price_s  = signed'({1'b0, w_price_ff});

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_SIGNAL;
            end
         end
         ST_SIGNAL: begin
            if (out_free) begin
               state_in = job_valid ? ST_PREP : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      div_req.start = (state_ff == ST_PREP);
      if (started_ff) begin
         div_req.num = (NUM_W'(w_mag_ff) << 1) + NUM_W'(UPD_HALF);
         div_req.dvs = DVS_W'(WINDOW + 1);
      end else begin
         div_req.num = (NUM_W'(w_total_ff) << EMA_FRAC_BITS) + NUM_W'(SEED_HALF);
         div_req.dvs = DVS_W'(WINDOW);
      end
   end

   always_comb begin
      if (!started_ff) begin
         ema_in = div_rsp.quotient[EMA_W-1:0];
      end else if (w_ge_ff) begin
         ema_in = ema_ff + div_rsp.quotient[EMA_W-1:0];
      end else begin
         ema_in = ema_ff - div_rsp.quotient[EMA_W-1:0];
      end
   end

   always_comb begin
      ema_buy  = (w_pfx < ema_ff) && !ema_hold_ff;
      ema_sell = (w_pfx > ema_ff) && ema_hold_ff;
      mom_buy  = !w_then_zero_ff && (lhs_ff > rhs_ff) && !mom_hold_ff;
      mom_sell = !w_then_zero_ff && (lhs_ff < rhs_ff) && mom_hold_ff;

      ema_hold_in = ema_hold_ff;
      ema_earn_in = ema_earn_ff;
      ema_act_in  = ACT_NONE;
      priority if (ema_buy) begin
         ema_hold_in = 1'b1;
         ema_earn_in = ema_buy_earn_ff;
         ema_act_in  = ACT_BUY;
      end else if (ema_sell) begin
         ema_hold_in = 1'b0;
         ema_earn_in = ema_sell_earn_ff;
         ema_act_in  = ACT_SELL;
      end

      mom_hold_in = mom_hold_ff;
      mom_earn_in = mom_earn_ff;
      mom_act_in  = ACT_NONE;
      priority if (mom_buy) begin
         mom_hold_in = 1'b1;
         mom_earn_in = mom_buy_earn_ff;
         mom_act_in  = ACT_BUY;
      end else if (mom_sell) begin
         mom_hold_in = 1'b0;
         mom_earn_in = mom_sell_earn_ff;
         mom_act_in  = ACT_SELL;
      end
   end

   always_comb begin
      priority if (sig_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= '0;
         ema_ff       <= '0;
         started_ff   <= 1'b0;
         ema_hold_ff  <= 1'b0;
         ema_earn_ff  <= '0;
         mom_hold_ff  <= 1'b0;
         mom_earn_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            thr_ff <= csr_momentum_threshold_pct;
         end
         if ((state_ff == ST_DIV) && div_rsp.done) begin
            ema_ff     <= ema_in;
            started_ff <= 1'b1;
         end
         if (sig_fire) begin
            ema_hold_ff <= ema_hold_in;
            ema_earn_ff <= ema_earn_in;
            mom_hold_ff <= mom_hold_in;
            mom_earn_ff <= mom_earn_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_take) begin
         w_price_ff     <= job.price;
         w_total_ff     <= job.total;
         w_then_zero_ff <= (job.then_val == '0);
         w_ge_ff        <= job_pfx >= ema_ff;
         w_mag_ff       <= (job_pfx >= ema_ff) ? job_pfx - ema_ff : ema_ff - job_pfx;
         lhs_ff         <= MOM_W'(signed'(job.mom_diff)) * MOM_W'(PCT_SCALE);
         rhs_ff         <= MOM_W'(thr_ff) * MOM_W'(signed'({1'b0, job.then_val}));
      end
      if (state_ff == ST_PREP) begin
         ema_buy_earn_ff  <= sat_add(ema_earn_ff, -price_s);
         ema_sell_earn_ff <= sat_add(ema_earn_ff, price_s);
         mom_buy_earn_ff  <= sat_add(mom_earn_ff, -price_s);
         mom_sell_earn_ff <= sat_add(mom_earn_ff, price_s);
      end
      if (sig_fire) begin
         rsp_level_ff      <= EMA_LEVEL_W'(ema_ff);
         rsp_ema_act_ff    <= ema_act_in;
         rsp_ema_pos_ff    <= ema_hold_in;
         rsp_ema_profit_ff <= ema_earn_in;
         rsp_mom_act_ff    <= mom_act_in;
         rsp_mom_pos_ff    <= mom_hold_in;
         rsp_mom_profit_ff <= mom_earn_in;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_ema_level            = rsp_level_ff;
   assign rsp_ema_action           = rsp_ema_act_ff;
   assign rsp_ema_in_position      = rsp_ema_pos_ff;
   assign rsp_ema_profit           = rsp_ema_profit_ff;
   assign rsp_momentum_action      = rsp_mom_act_ff;
   assign rsp_momentum_in_position = rsp_mom_pos_ff;
   assign rsp_momentum_profit      = rsp_mom_profit_ff;

endmodule

// File: hw/rtl/ema_and_momentum_price_signal_top.sv
// ----------------------------------------------------------------------------
// EMA and momentum price signal
//
//   Channel   Ports                       Beat
//   request   req_valid / req_ready       one trade price
//   response  rsp_valid / rsp_ready       average and momentum moves, earnings
//   config    csr_wr_en                   momentum threshold in percent
//
// A price that gives no response goes no further than the ring stage.
// A price that gives a response also passes through the core, where the
// restoring divider in the moving average update works 8 quotient bits a cycle.
// The ring stage takes the next price while the core works on the previous one.
// Reset is synchronous; the price ring memory is not cleared.
// A stalled response holds in the output register and stops the core.
// ----------------------------------------------------------------------------
module ema_and_momentum_price_signal_top
   import ema_mom_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [PRICE_W-1:0]       req_trade_price,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [EMA_LEVEL_W-1:0]   rsp_ema_level,
   output logic [ACTION_W-1:0]      rsp_ema_action,
   output logic                     rsp_ema_in_position,
   output logic signed [EARN_W-1:0] rsp_ema_profit,
   output logic [ACTION_W-1:0]      rsp_momentum_action,
   output logic                     rsp_momentum_in_position,
   output logic signed [EARN_W-1:0] rsp_momentum_profit,
   input  logic                     csr_wr_en,
   input  logic signed [THR_W-1:0]  csr_momentum_threshold_pct
);

   logic    job_valid;
   logic    job_take;
   job_type job;

   ema_mom_ring u_ring (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_trade_price (req_trade_price),
      .job_take        (job_take),
      .job_valid       (job_valid),
      .job             (job)
   );

   ema_mom_core u_core (
      .clock                      (clock),
      .reset                      (reset),
      .csr_wr_en                  (csr_wr_en),
      .csr_momentum_threshold_pct (csr_momentum_threshold_pct),
      .job_valid                  (job_valid),
      .job                        (job),
      .job_take                   (job_take),
      .rsp_valid                  (rsp_valid),
      .rsp_ready                  (rsp_ready),
      .rsp_ema_level              (rsp_ema_level),
      .rsp_ema_action             (rsp_ema_action),
      .rsp_ema_in_position        (rsp_ema_in_position),
      .rsp_ema_profit             (rsp_ema_profit),
      .rsp_momentum_action        (rsp_momentum_action),
      .rsp_momentum_in_position   (rsp_momentum_in_position),
      .rsp_momentum_profit        (rsp_momentum_profit)
   );

endmodule

// File: hw/rtl/ema_mom_checker.sv
// ----------------------------------------------------------------------------
// EMA and momentum signal checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "ema_and_momentum_price_signal_top_macros.svh"

module ema_mom_checker
   import ema_mom_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic [PRICE_W-1:0]       req_trade_price,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [EMA_LEVEL_W-1:0]   rsp_ema_level,
   input logic [ACTION_W-1:0]      rsp_ema_action,
   input logic                     rsp_ema_in_position,
   input logic signed [EARN_W-1:0] rsp_ema_profit,
   input logic [ACTION_W-1:0]      rsp_momentum_action,
   input logic                     rsp_momentum_in_position,
   input logic signed [EARN_W-1:0] rsp_momentum_profit,
   input logic                     csr_wr_en,
   input logic signed [THR_W-1:0]  csr_momentum_threshold_pct
);

   `EMA_MOM_ASSERT_NEXT(a_ready_after_accept, req_valid && req_ready, !req_ready, "ready stayed high after a request beat")
   `EMA_MOM_ASSERT_IMPL(a_ema_position, rsp_valid && (rsp_ema_action != ACT_NONE), rsp_ema_in_position == (rsp_ema_action == ACT_BUY), "average position disagrees with its move")
   `EMA_MOM_ASSERT_IMPL(a_mom_position, rsp_valid && (rsp_momentum_action != ACT_NONE), rsp_momentum_in_position == (rsp_momentum_action == ACT_BUY), "momentum position disagrees with its move")
   `EMA_MOM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_ema_profit) && $stable(rsp_momentum_profit), "stalled response beat changed")
   `EMA_MOM_ASSERT_IMPL(a_reset_quiet, $fell(reset), !rsp_valid, "response beat present right after reset")

endmodule

bind ema_and_momentum_price_signal_top ema_mom_checker u_ema_mom_checker (.*);
